// ===== sv/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int NUM_MATCH_ADDRESSES = 10;
    localparam int MATCH_IDX_W = (NUM_MATCH_ADDRESSES > 1) ? $clog2(NUM_MATCH_ADDRESSES) : 1;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [4:0] OFF_DATA    = 5'h00;
    localparam logic [4:0] OFF_STATUS  = 5'h02;
    localparam logic [4:0] OFF_CST     = 5'h04;
    localparam logic [4:0] OFF_CTL1    = 5'h06;
    localparam logic [4:0] OFF_MATCH0  = 5'h08;
    localparam logic [4:0] OFF_CTL2    = 5'h0a;
    localparam logic [4:0] OFF_MATCH1  = 5'h0c;
    localparam logic [4:0] OFF_CTL3    = 5'h0e;
    localparam logic [4:0] OFF_CST2    = 5'h18;
    localparam logic [4:0] OFF_CST3    = 5'h19;
    localparam logic [4:0] OFF_CTL4    = 5'h1a;
    localparam logic [4:0] OFF_CTL5    = 5'h1b;
    localparam logic [4:0] OFF_CLK_LO  = 5'h1c;
    localparam logic [4:0] OFF_CLK_HI  = 5'h1e;
    localparam logic [4:0] OFF_VERSION = 5'h1f;

    localparam logic [7:0] VERSION_VALUE = 8'h01;

    localparam logic [2:0] PH_IDLE        = 3'd0;
    localparam logic [2:0] PH_SEND        = 3'd1;
    localparam logic [2:0] PH_RECV        = 3'd2;
    localparam logic [2:0] PH_NEGACK      = 3'd3;
    localparam logic [2:0] PH_STOP_RECV   = 3'd4;
    localparam logic [2:0] PH_STOP_NEGACK = 3'd5;

    localparam logic [7:0] CST_RESET  = 8'h10;
    localparam logic [7:0] CTL3_RESET = 8'hc0;
    localparam logic [7:0] CTL4_RESET = 8'h07;

    localparam logic [7:0] STATUS_W1C_MASK = 8'hac;
    localparam logic [7:0] CTL1_KEEP_MASK  = 8'h13;
    localparam logic [7:0] START_SET_MASK  = 8'h43;

    typedef logic [3:0] match_idx_raw_t;

    typedef struct packed {
        logic       command;
        logic [4:0] reg_offset;
        logic [7:0] write_data;
        logic       bus_busy;
        logic       target_ack;
        logic [7:0] target_byte;
    } i2cm_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_level;
        logic       start_strobe;
        logic [6:0] target_address;
        logic       read_direction;
        logic       send_strobe;
        logic [7:0] send_value;
        logic       receive_strobe;
        logic       nack_strobe;
        logic       stop_strobe;
    } i2cm_rsp_t;

    // banked offsets 0x10..0x17 to match table entry
    function automatic match_idx_raw_t bank_match_idx(input logic [2:0] sel);
        match_idx_raw_t idx;
        unique case (sel)
            3'd0:    idx = 4'd2;
            3'd1:    idx = 4'd6;
            3'd2:    idx = 4'd3;
            3'd3:    idx = 4'd7;
            3'd4:    idx = 4'd4;
            3'd5:    idx = 4'd8;
            3'd6:    idx = 4'd5;
            3'd7:    idx = 4'd9;
            default: idx = 4'd0;
        endcase
        return idx;
    endfunction

    function automatic logic irq_lvl(input logic [7:0] ctl1, input logic [7:0] st,
                                     input logic [7:0] cst3);
        return (ctl1[6] & st[2]) | st[4] | st[5] | st[6] | (ctl1[3] & cst3[7]);
    endfunction

endpackage

// ===== sv/i2cm_if.sv =====
`timescale 1ns / 1ps

interface i2cm_req_if
    import i2cm_pkg::*;
;
    logic      valid;
    logic      ready;
    i2cm_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface i2cm_rsp_if
    import i2cm_pkg::*;
;
    logic      valid;
    logic      ready;
    i2cm_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/i2c_master_register_controller_unit.sv =====
`timescale 1ns / 1ps
// An accepted request beat passes through the input register, then decode/update into
// the response register, before its response beat.
// Throughput: one access per cycle while rsp.ready holds; a response may wait while the next request is taken.
// Reset (rst_n low, asynchronous): all registers, match table, transfer phase
// and interrupt line go to their reset values; both pipeline stages empty.

module i2c_master_register_controller_unit
    import i2cm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    i2cm_req_if.sink   req,
    i2cm_rsp_if.source rsp
);

    localparam logic [2:0] PK_NONE   = 3'd0;
    localparam logic [2:0] PK_MATCH  = 3'd1;
    localparam logic [2:0] PK_CTL4   = 3'd2;
    localparam logic [2:0] PK_CTL5   = 3'd3;
    localparam logic [2:0] PK_CLK_LO = 3'd4;
    localparam logic [2:0] PK_CLK_HI = 3'd5;

    logic      in_valid_reg;
    i2cm_req_t in_data_reg;
    logic      rsp_valid_reg;
    i2cm_rsp_t rsp_data_reg;
    logic      adv;
    logic      fire;

    logic [7:0] status_reg, status_next;
    logic [7:0] cst_reg, cst_next;
    logic [7:0] cst2_reg, cst2_next;
    logic [7:0] cst3_reg, cst3_next;
    logic [7:0] ctl1_reg, ctl1_next;
    logic [7:0] ctl2_reg, ctl2_next;
    logic [7:0] ctl3_reg, ctl3_next;
    logic [7:0] ctl4_reg, ctl4_next;
    logic [7:0] ctl5_reg, ctl5_next;
    logic [7:0] data_reg, data_next;
    logic [2:0] phase_reg, phase_next;
    logic [7:0] clk_lo_reg, clk_lo_next;
    logic [7:0] clk_hi_reg, clk_hi_next;
    logic       irq_reg, irq_next;
    logic [7:0] match_reg [NUM_MATCH_ADDRESSES];
    logic [7:0] match_next [NUM_MATCH_ADDRESSES];

    logic [2:0]           plain_kind;
    match_idx_raw_t       idx_raw;
    logic [MATCH_IDX_W-1:0] match_idx;
    logic [7:0]           plain_val;
    i2cm_rsp_t            rsp_next;
    logic                 do_take;
    logic                 do_end;
    logic                 do_refresh;
    logic                 lvl;
    logic                 rd_dir;
    logic [7:0]           wv;

    assign adv       = !rsp_valid_reg || rsp.ready;
    assign req.ready = !in_valid_reg || adv;
    assign fire      = in_valid_reg && adv;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // plain byte registers: match table and bank-0 registers
    always_comb
    begin
        plain_kind = PK_NONE;
        idx_raw    = '0;
        if (in_data_reg.reg_offset == OFF_MATCH0)
        begin
            plain_kind = PK_MATCH;
        end
        else if (in_data_reg.reg_offset == OFF_MATCH1)
        begin
            plain_kind = PK_MATCH;
            idx_raw    = 4'd1;
        end
        else if (ctl3_reg[5])
        begin
            plain_kind = PK_NONE;
        end
        else if (in_data_reg.reg_offset[4:3] == 2'b10)
        begin
            plain_kind = PK_MATCH;
            idx_raw    = bank_match_idx(in_data_reg.reg_offset[2:0]);
        end
        else if (in_data_reg.reg_offset == OFF_CTL4)
        begin
            plain_kind = PK_CTL4;
        end
        else if (in_data_reg.reg_offset == OFF_CTL5)
        begin
            plain_kind = PK_CTL5;
        end
        else if (in_data_reg.reg_offset == OFF_CLK_LO)
        begin
            plain_kind = PK_CLK_LO;
        end
        else if (in_data_reg.reg_offset == OFF_CLK_HI)
        begin
            plain_kind = PK_CLK_HI;
        end
        if (plain_kind == PK_MATCH && int'(idx_raw) >= NUM_MATCH_ADDRESSES)
        begin
            plain_kind = PK_NONE;
        end
    end

    assign match_idx = idx_raw[MATCH_IDX_W-1:0];

    always_comb
    begin
        unique case (plain_kind)
            PK_MATCH:  plain_val = match_reg[match_idx];
            PK_CTL4:   plain_val = ctl4_reg;
            PK_CTL5:   plain_val = ctl5_reg;
            PK_CLK_LO: plain_val = clk_lo_reg;
            PK_CLK_HI: plain_val = clk_hi_reg;
            default:   plain_val = 8'h00;
        endcase
    end

    always_comb
    begin
        status_next = status_reg;
        cst_next    = cst_reg;
        cst2_next   = cst2_reg;
        cst3_next   = cst3_reg;
        ctl1_next   = ctl1_reg;
        ctl2_next   = ctl2_reg;
        ctl3_next   = ctl3_reg;
        ctl4_next   = ctl4_reg;
        ctl5_next   = ctl5_reg;
        data_next   = data_reg;
        phase_next  = phase_reg;
        clk_lo_next = clk_lo_reg;
        clk_hi_next = clk_hi_reg;
        irq_next    = irq_reg;
        match_next  = match_reg;
        rsp_next    = '0;
        do_take     = 1'b0;
        do_end      = 1'b0;
        do_refresh  = 1'b0;
        wv          = in_data_reg.write_data;
        rd_dir      = wv[0];
        lvl         = 1'b0;

        if (in_data_reg.command == CMD_WRITE)
        begin
            unique case (in_data_reg.reg_offset)
                OFF_DATA:
                begin
                    data_next = wv;
                    if (status_reg[1] && phase_reg == PH_IDLE)
                    begin
                        // start/address beat
                        rsp_next.start_strobe   = 1'b1;
                        rsp_next.target_address = wv[7:1];
                        rsp_next.read_direction = rd_dir;
                        status_next[0]          = !rd_dir;
                        if (!in_data_reg.target_ack)
                        begin
                            status_next[6] = 1'b0;
                            status_next[4] = 1'b1;
                            phase_next     = PH_NEGACK;
                        end
                        else
                        begin
                            status_next[4] = 1'b0;
                            phase_next     = rd_dir ? PH_RECV : PH_SEND;
                            if (ctl1_reg[7])
                            begin
                                // stall after address
                                status_next[3] = 1'b1;
                                if (!rd_dir)
                                begin
                                    status_next[6] = 1'b1;
                                end
                            end
                            else if (rd_dir)
                            begin
                                do_take = 1'b1;
                            end
                        end
                        do_refresh = 1'b1;
                    end
                    else if (status_reg[1] && phase_reg == PH_SEND)
                    begin
                        rsp_next.send_strobe = 1'b1;
                        rsp_next.send_value  = wv;
                        if (!in_data_reg.target_ack)
                        begin
                            status_next[6] = 1'b0;
                            status_next[4] = 1'b1;
                            phase_next     = PH_NEGACK;
                        end
                        else
                        begin
                            status_next[6] = 1'b1;
                        end
                        do_refresh = 1'b1;
                    end
                end
                OFF_STATUS:
                begin
                    status_next = status_reg & ~(wv & STATUS_W1C_MASK);
                    if (wv[4])
                    begin
                        status_next[4] = 1'b0;
                        if (phase_reg == PH_STOP_NEGACK)
                        begin
                            do_end = 1'b1;
                        end
                    end
                    if (wv[3] && phase_reg == PH_RECV)
                    begin
                        do_take = 1'b1;
                    end
                    do_refresh = 1'b1;
                end
                OFF_CST:
                begin
                    if (wv[1])
                    begin
                        cst_next[1] = 1'b0;
                    end
                    do_refresh = 1'b1;
                end
                OFF_CTL1:
                begin
                    ctl1_next = (wv & ~CTL1_KEEP_MASK) | (ctl1_reg & CTL1_KEEP_MASK);
                    if (wv[0])
                    begin
                        if (!in_data_reg.bus_busy || phase_reg != PH_IDLE)
                        begin
                            status_next = status_next | START_SET_MASK;
                            cst_next[0] = 1'b1;
                        end
                        else
                        begin
                            // bus held by another master
                            status_next[1] = 1'b0;
                            cst_next[0]    = 1'b0;
                            status_next[5] = 1'b1;
                        end
                        cst_next[1] = 1'b1;
                        phase_next  = PH_IDLE;
                    end
                    if (wv[1] && status_next[1])
                    begin
                        if (phase_next == PH_RECV || phase_next == PH_STOP_RECV)
                        begin
                            phase_next = PH_STOP_RECV;
                        end
                        else if (phase_next == PH_NEGACK)
                        begin
                            phase_next = PH_STOP_NEGACK;
                        end
                        else
                        begin
                            do_end = 1'b1;
                        end
                    end
                    do_refresh = 1'b1;
                end
                OFF_CTL2:
                begin
                    ctl2_next = wv;
                    if (!wv[0])
                    begin
                        ctl1_next    = 8'h00;
                        status_next  = 8'h00;
                        cst3_next[7] = 1'b0;
                        cst_next     = 8'h00;
                    end
                end
                OFF_CTL3:
                begin
                    ctl3_next = {ctl3_reg[7:6], wv[5:0]};
                end
                OFF_CST3:
                begin
                    if (wv[7])
                    begin
                        cst3_next[7] = 1'b0;
                    end
                    do_refresh = 1'b1;
                end
                OFF_CST2, OFF_VERSION:
                begin
                end
                default:
                begin
                    unique case (plain_kind)
                        PK_MATCH:  match_next[match_idx] = wv;
                        PK_CTL4:   ctl4_next = wv;
                        PK_CTL5:   ctl5_next = wv;
                        PK_CLK_LO: clk_lo_next = wv;
                        PK_CLK_HI: clk_hi_next = wv;
                        default:   ;
                    endcase
                end
            endcase
        end
        else
        begin
            unique case (in_data_reg.reg_offset)
                OFF_DATA:
                begin
                    rsp_next.read_data = data_reg;
                    if (phase_reg == PH_STOP_RECV)
                    begin
                        do_end = 1'b1;
                    end
                    else if (phase_reg == PH_RECV)
                    begin
                        do_take = 1'b1;
                    end
                end
                OFF_STATUS:  rsp_next.read_data = status_reg;
                OFF_CST:     rsp_next.read_data = cst_reg;
                OFF_CTL1:    rsp_next.read_data = ctl1_reg;
                OFF_CTL2:    rsp_next.read_data = ctl2_reg;
                OFF_CTL3:    rsp_next.read_data = ctl3_reg;
                OFF_CST2:    rsp_next.read_data = cst2_reg;
                OFF_CST3:    rsp_next.read_data = cst3_reg;
                OFF_VERSION: rsp_next.read_data = VERSION_VALUE;
                default:     rsp_next.read_data = plain_val;
            endcase
        end

        // byte taken from target
        if (do_take)
        begin
            data_next               = in_data_reg.target_byte;
            rsp_next.receive_strobe = 1'b1;
            status_next[6]          = 1'b1;
            if (ctl1_next[4])
            begin
                rsp_next.nack_strobe = 1'b1;
                ctl1_next[4]         = 1'b0;
            end
            do_refresh = 1'b1;
        end

        // stop
        if (do_end)
        begin
            rsp_next.stop_strobe = 1'b1;
            status_next          = 8'h00;
            cst_next             = 8'h00;
            phase_next           = PH_IDLE;
            cst3_next[7]         = 1'b1;
            do_refresh           = 1'b1;
        end

        lvl = irq_lvl(ctl1_next, status_next, cst3_next);
        if (do_refresh && ctl1_next[2])
        begin
            cst2_next[7] = lvl;
            irq_next     = lvl;
        end

        rsp_next.irq_level = irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (adv)
            begin
                rsp_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_data_reg <= req.data;
        end
        if (fire)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= 8'h00;
            cst_reg    <= CST_RESET;
            cst2_reg   <= 8'h00;
            cst3_reg   <= 8'h00;
            ctl1_reg   <= 8'h00;
            ctl2_reg   <= 8'h00;
            ctl3_reg   <= CTL3_RESET;
            ctl4_reg   <= CTL4_RESET;
            ctl5_reg   <= 8'h00;
            data_reg   <= 8'h00;
            phase_reg  <= PH_IDLE;
            clk_lo_reg <= 8'h00;
            clk_hi_reg <= 8'h00;
            irq_reg    <= 1'b0;
            for (int i = 0; i < NUM_MATCH_ADDRESSES; i++)
            begin
                match_reg[i] <= 8'h00;
            end
        end
        else if (fire)
        begin
            status_reg <= status_next;
            cst_reg    <= cst_next;
            cst2_reg   <= cst2_next;
            cst3_reg   <= cst3_next;
            ctl1_reg   <= ctl1_next;
            ctl2_reg   <= ctl2_next;
            ctl3_reg   <= ctl3_next;
            ctl4_reg   <= ctl4_next;
            ctl5_reg   <= ctl5_next;
            data_reg   <= data_next;
            phase_reg  <= phase_next;
            clk_lo_reg <= clk_lo_next;
            clk_hi_reg <= clk_hi_next;
            irq_reg    <= irq_next;
            match_reg  <= match_next;
        end
    end

endmodule
